/* rtl/pds_pkg.sv */
// Shared types, constants and helper functions of the percent decoder.
`default_nettype none

package pds_pkg;

    localparam int unsigned CMD_DEPTH_DEF = 4;

    localparam logic [7:0] PCT_CHAR    = 8'h25;
    localparam logic [7:0] QUOTE_DIGIT = 8'h32;
    localparam logic [7:0] NUL_CHAR    = 8'h00;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    // One decoded request: up to three bytes, sent in order; last marks the
    // final byte as the string terminator.
    typedef struct packed {
        logic [1:0]      cnt;
        logic            last;
        logic [7:0]      char2;
        logic [7:0]      char1;
        logic [7:0]      char0;
    } cmd_t;

    function automatic logic is_hex(input logic [7:0] c);
        logic res;
        res = ((c >= 8'h30) && (c <= 8'h39)) ||
              ((c >= 8'h41) && (c <= 8'h46)) ||
              ((c >= 8'h61) && (c <= 8'h66));
        return res;
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c <= 8'h39)
        begin
            v = c - 8'h30;
        end
        else if (c <= 8'h46)
        begin
            v = c - 8'h37;
        end
        else
        begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/percent_decode_stream.sv */
// Top level of the streaming percent decoder.
//
//   Channel  | Direction | Handshake           | Payload
//   ---------+-----------+---------------------+----------------------
//   input    | in        | push / full         | char_in[7:0]
//   results  | out       | empty / pop         | char_out[7:0], last
//
// A byte is taken in every cycle that push is high and full is low; each
// byte becomes one request of up to three result bytes in the front end.
// Results leave at one per cycle while pop takes them, from the back end's
// output register, so a byte that causes three results holds the back end
// while the request queue (CMD_DEPTH entries) keeps the input side running.
// A byte's first result passes the request queue, then the output register.
// Reset (rst_n low, asynchronous) empties the queue and returns the escape
// tracker to idle; full rises when long requests or stalled pops fill it.
`default_nettype none

module percent_decode_stream
    import pds_pkg::*;
#(
    parameter int unsigned CMD_DEPTH = CMD_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] char_in,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      char_out,
    output logic            last
);

    cmd_t fe_cmd;
    logic fe_cmd_valid;
    cmd_t q_head;
    logic q_empty;
    logic q_full;
    logic be_head_done;
    logic accept;

    // A byte is accepted whenever the request queue has room, even while a
    // finished result still waits on the output register.
    assign accept = push && !q_full;
    assign full   = q_full;

    pds_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_in   (char_in),
        .cmd       (fe_cmd),
        .cmd_valid (fe_cmd_valid)
    );

    // Requests that produce nothing (a held percent sign or digit, or the
    // dropped quote escape) are never written to the queue.
    pds_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fe_cmd_valid),
        .wr_data (fe_cmd),
        .full    (q_full),
        .rd_en   (be_head_done),
        .rd_data (q_head),
        .empty   (q_empty)
    );

    pds_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .head_valid (!q_empty),
        .head_done  (be_head_done),
        .pop        (pop),
        .empty      (empty),
        .char_out   (char_out),
        .last       (last)
    );

endmodule

`default_nettype wire

/* rtl/pds_front.sv */
// Front end: tracks the escape phase and turns each byte into a request.
`default_nettype none

module pds_front
    import pds_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] char_in,
    output cmd_t            cmd,
    output logic            cmd_valid
);

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;

    // Next state of the escape tracker.
    always_comb
    begin
        phase_next = phase_reg;
        held_next  = held_reg;
        case (phase_reg)
            PH_PCT:
            begin
                if (is_hex(char_in))
                begin
                    held_next  = char_in;
                    phase_next = PH_DIGIT;
                end
                else if (char_in == PCT_CHAR)
                begin
                    phase_next = PH_PCT;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_DIGIT:
            begin
                held_next = NUL_CHAR;
                if (!is_hex(char_in) && (char_in == PCT_CHAR))
                begin
                    phase_next = PH_PCT;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                if (char_in == PCT_CHAR)
                begin
                    phase_next = PH_PCT;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
                if (char_in == NUL_CHAR)
                begin
                    held_next = NUL_CHAR;
                end
            end
        endcase
    end

    // Request built from the current phase and the incoming byte.
    always_comb
    begin
        cmd.cnt   = 2'd0;
        cmd.last  = 1'b0;
        cmd.char0 = char_in;
        cmd.char1 = char_in;
        cmd.char2 = char_in;
        case (phase_reg)
            PH_PCT:
            begin
                if (!is_hex(char_in))
                begin
                    cmd.char0 = PCT_CHAR;
                    if (char_in == PCT_CHAR)
                    begin
                        cmd.cnt = 2'd1;
                    end
                    else
                    begin
                        cmd.cnt  = 2'd2;
                        cmd.last = (char_in == NUL_CHAR);
                    end
                end
            end
            PH_DIGIT:
            begin
                if (is_hex(char_in))
                begin
                    cmd.char0 = {hex_val(held_reg), hex_val(char_in)};
                    if (!((held_reg == QUOTE_DIGIT) && (char_in == QUOTE_DIGIT)))
                    begin
                        cmd.cnt = 2'd1;
                    end
                end
                else
                begin
                    cmd.char0 = PCT_CHAR;
                    cmd.char1 = held_reg;
                    if (char_in == PCT_CHAR)
                    begin
                        cmd.cnt = 2'd2;
                    end
                    else
                    begin
                        cmd.cnt  = 2'd3;
                        cmd.last = (char_in == NUL_CHAR);
                    end
                end
            end
            default:
            begin
                if (char_in != PCT_CHAR)
                begin
                    cmd.cnt  = 2'd1;
                    cmd.last = (char_in == NUL_CHAR);
                end
            end
        endcase
    end

    assign cmd_valid = accept && (cmd.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= NUL_CHAR;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/pds_cmd_fifo.sv */
// Short request queue between the front end and the back end.
`default_nettype none

module pds_cmd_fifo
    import pds_pkg::*;
#(
    parameter int unsigned DEPTH = CMD_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire cmd_t wr_data,
    output logic      full,
    input  wire logic rd_en,
    output cmd_t      rd_data,
    output logic      empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == FULL_CNT);
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/pds_back.sv */
// Back end: unrolls queued requests into single bytes on an output register.
`default_nettype none

module pds_back
    import pds_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cmd_t       head,
    input  wire logic       head_valid,
    output logic            head_done,
    input  wire logic       pop,
    output logic            empty,
    output logic [7:0]      char_out,
    output logic            last
);

    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] char_reg;
    logic       last_reg;
    logic       load, at_end;
    logic [7:0] sel_char;

    assign load   = head_valid && (!out_valid_reg || pop);
    assign at_end = (idx_reg == (head.cnt - 2'd1));

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_char = head.char0;
            2'd1:    sel_char = head.char1;
            default: sel_char = head.char2;
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        head_done      = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (at_end)
            begin
                idx_next  = 2'd0;
                head_done = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            char_reg <= sel_char;
            last_reg <= head.last && at_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty    = !out_valid_reg;
    assign char_out = char_reg;
    assign last     = last_reg;

endmodule

`default_nettype wire

/* rtl/pds_checker.sv */
// Port-level checks for the percent decoder and their binding.
`default_nettype none

module pds_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       push,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] char_out,
    input wire logic       last
);

    // A waiting result that is not taken stays as it is.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(char_out) && $stable(last)))
        else $error("result changed while waiting");

    // The terminator is always a zero byte.
    a_last_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last) |-> (char_out == 8'h00))
        else $error("terminator with non-zero byte");

    // A full queue means a result is already on offer.
    a_full_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("queue full with no result on offer");

    // Input is never refused straight after a reset.
    a_reset_not_full: assert property (@(posedge clk)
        !rst_n |=> !full)
        else $error("full asserted out of reset");

    // A push is refused by a full queue only while a result is on offer.
    a_push_into_full: assert property (@(posedge clk) disable iff (!rst_n)
        (push && full) |-> !empty)
        else $error("push refused with no result pending");

endmodule

bind percent_decode_stream pds_checker u_pds_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .char_out (char_out),
    .last     (last)
);

`default_nettype wire
